// File: src/vsc_pkg.sv
// vsc_pkg: shared constants, command codes and types of the vector stack calculator
// used by vsc_front, vsc_back, vector_stack_calculator and vsc_checker
`default_nettype none

package vsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_OUT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDER  = 2'd1;
  localparam logic [1:0] ST_OVER   = 2'd2;
  localparam logic [1:0] ST_BADCMD = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_ADD,
    OP_OUT,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/vsc_front.sv
// vsc_front: accepts command beats, decodes func and holds them in a two-entry queue
// depends on vsc_pkg
`default_nettype none

module vsc_front
  import vsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_x_in,
  input  wire logic signed [31:0] in_y_in,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  wire logic               cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       enq;
  logic       deq;
  cmd_t       dec;

  always_comb begin
    dec.x = in_x_in;
    dec.y = in_y_in;
    unique case (in_func)
      FUNC_PUSH: dec.op = OP_PUSH;
      FUNC_ADD:  dec.op = OP_ADD;
      FUNC_OUT:  dec.op = OP_OUT;
      default:   dec.op = OP_BAD;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign enq       = in_push && !in_full;
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (enq) begin
        q_r[wr_ptr_r] <= dec;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

`default_nettype wire

// File: src/vsc_back.sv
// vsc_back: executes queued commands against the vector stack and holds the result beat
// depends on vsc_pkg; the stack store is a two-read, one-write memory with registered reads
`default_nettype none

module vsc_back
  import vsc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire cmd_t          cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [1:0]         out_status,
  output logic               out_has_value,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  op_t                op_r, op_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_has_r, out_has_nxt;
  logic [31:0]        out_x_r, out_x_nxt;
  logic [31:0]        out_y_r, out_y_nxt;

  logic [63:0]        mem [STACK_DEPTH];
  logic [63:0]        rd_a_r, rd_b_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, ra, rb;
  logic [63:0]        mem_wdata;

  logic               slot_free;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2;
  logic [31:0]        sum_x, sum_y;

  assign slot_free = !out_valid_r || out_pop;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign sum_x     = rd_a_r[31:0] + rd_b_r[31:0];
  assign sum_y     = rd_a_r[63:32] + rd_b_r[63:32];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_status_nxt = out_status_r;
    out_has_nxt    = out_has_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = cnt_r[ADDR_W-1:0];
    mem_wdata      = {cmd.y, cmd.x};
    ra             = cnt_m1[ADDR_W-1:0];
    rb             = (cmd.op == OP_ADD) ? cnt_m2[ADDR_W-1:0] : '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop        = 1'b1;
          op_nxt         = cmd.op;
          out_status_nxt = ST_OK;
          out_has_nxt    = 1'b0;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_valid_nxt  = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                out_status_nxt = ST_OVER;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_ADD: begin
              if (cnt_r < CNT_W'(2)) begin
                out_status_nxt = ST_UNDER;
              end else begin
                mem_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_EXEC;
              end
            end
            OP_OUT: begin
              if (cnt_r == '0) begin
                out_status_nxt = ST_UNDER;
              end else begin
                mem_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_EXEC;
              end
            end
            default: begin
              out_status_nxt = ST_BADCMD;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        cnt_nxt        = cnt_m1;
        if (op_r == OP_ADD) begin
          mem_we      = 1'b1;
          mem_waddr   = cnt_m2[ADDR_W-1:0];
          mem_wdata   = {sum_y, sum_x};
          out_has_nxt = 1'b0;
          out_x_nxt   = '0;
          out_y_nxt   = '0;
        end else begin
          out_has_nxt = 1'b1;
          out_x_nxt   = rd_a_r[31:0];
          out_y_nxt   = rd_a_r[63:32];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // stack store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      out_status_r <= out_status_nxt;
      out_has_r    <= out_has_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_status    = out_status_r;
  assign out_has_value = out_has_r;
  assign out_x_out     = out_x_r;
  assign out_y_out     = out_y_r;

endmodule

`default_nettype wire

// File: src/vector_stack_calculator.sv
// vector_stack_calculator: top level, front decoder and queue feeding the stack execution unit
// depends on vsc_pkg, vsc_front, vsc_back
//
// A stack of up to 16 two-component 32-bit vectors, driven one command beat at a time:
// push (x,y), add the top two with each component wrapping, or pop and output the top.
// Every command beat yields exactly one result beat with a status (ok, underflow,
// overflow, unknown command); a failing command leaves the stack unchanged, and any
// result without a popped vector carries zero components. Commands enter a two-entry
// queue, so up to two may be taken while the execution unit or the result side stalls.
// Push, unknown commands and failing commands are completed in the idle state of the
// execution unit; a successful add or output also passes through the execute state, for
// the registered read of the stack memory. The unit takes no new command until it is
// through with the last one. No clearing pass is needed after reset.
`default_nettype none

module vector_stack_calculator
  import vsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_x_in,
  input  wire logic signed [31:0] in_y_in,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [1:0]              out_status,
  output logic                    out_has_value,
  output logic signed [31:0]      out_x_out,
  output logic signed [31:0]      out_y_out
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  vsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  vsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_has_value (out_has_value),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out)
  );

endmodule

`default_nettype wire

// File: src/vsc_checker.sv
// vsc_checker: port-level assertions for vector_stack_calculator, bound to the top level
// depends on vsc_pkg
`default_nettype none

module vsc_checker
  import vsc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic [1:0]         out_status,
  input wire logic               out_has_value,
  input wire logic signed [31:0] out_x_out,
  input wire logic signed [31:0] out_y_out
);

  // both sides come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a waiting result beat holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) &&
      $stable(out_has_value) && $stable(out_x_out) && $stable(out_y_out)))
    else $error("result beat changed while stalled");

  // a popped vector only comes with ok status
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_has_value) |-> (out_status == ST_OK))
    else $error("vector returned with error status");

  // failing commands return zero components and no vector
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |->
      (!out_has_value && out_x_out == 32'sd0 && out_y_out == 32'sd0))
    else $error("error result carries data");

  // an input beat right after reset is always taken
  a_first_in: assert property (@(posedge clk)
    (!rst_n ##1 rst_n) |-> !in_full)
    else $error("input full right after reset");

endmodule

bind vector_stack_calculator vsc_checker u_vsc_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for vector_stack_calculator, using vsc_pkg
// a queue-fed driver and a monitor with random idling; an in-bench stack predictor
// computes each result beat, which is checked in order against the block's output

module testbench;
  import vsc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_value;
    logic [31:0] x;
    logic [31:0] y;
  } vsc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [1:0]          in_func = FUNC_PUSH;
  logic signed [31:0]  in_x_in = '0;
  logic signed [31:0]  in_y_in = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [1:0]          out_status;
  logic                out_has_value;
  logic signed [31:0]  out_x_out;
  logic signed [31:0]  out_y_out;

  cmd_t         cmd_backlog[$];
  vsc_result_t  results_due[$];
  cmd_t         next_cmd;
  logic [31:0]  stack_x[STACK_DEPTH];
  logic [31:0]  stack_y[STACK_DEPTH];
  int           stack_fill = 0;
  int           n_total = 0;
  int           n_accepted = 0;
  int           mismatches = 0;
  int           push_gap = 0;
  int           push_quiet = 0;
  int           pop_stall = 0;
  int           pop_quiet = 0;

  vector_stack_calculator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_x_in       (in_x_in),
    .in_y_in       (in_y_in),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_has_value (out_has_value),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 32'h0000_0000;
    if (r < 4) return 32'hffff_ffff;
    if (r < 6) return 32'h7fff_ffff;
    if (r < 8) return 32'h8000_0000;
    if (r < 9) return 32'h0000_0001;
    return $urandom;
  endfunction

  task automatic add_cmd(input op_t op, input logic [31:0] x, input logic [31:0] y);
    cmd_t c;
    c.op = op;
    c.x  = x;
    c.y  = y;
    cmd_backlog.push_back(c);
    n_total++;
  endtask

  task automatic build_stimulus();
    logic [31:0] pat;
    int          mode;
    int          len;
    int          r;
    int          push_lim;
    int          add_lim;
    // empty stack, unknown command, wrap of both components
    add_cmd(OP_OUT, 32'h0, 32'h0);
    add_cmd(OP_BAD, 32'hffff_ffff, 32'hffff_ffff);
    add_cmd(OP_PUSH, 32'h7fff_ffff, 32'h8000_0000);
    add_cmd(OP_ADD, 32'h0, 32'h0);
    add_cmd(OP_PUSH, 32'h0000_0001, 32'h8000_0000);
    add_cmd(OP_ADD, 32'h0, 32'h0);
    add_cmd(OP_OUT, 32'h0, 32'h0);
    add_cmd(OP_OUT, 32'h0, 32'h0);
    // fill to the top, then overflow
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (i % 4)
        0: pat = 32'h0000_0000;
        1: pat = 32'hffff_ffff;
        2: pat = 32'h5555_5555;
        default: pat = 32'haaaa_aaaa;
      endcase
      add_cmd(OP_PUSH, pat, ~pat);
    end
    add_cmd(OP_PUSH, 32'h1234_5678, 32'h9abc_def0);
    add_cmd(OP_ADD, 32'h0, 32'h0);
    add_cmd(OP_OUT, 32'h0, 32'h0);
    // random phases biased toward filling, draining or neither
    while (n_total < 1500) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(30, 90);
      case (mode)
        0: begin
          push_lim = 60;
          add_lim  = 75;
        end
        1: begin
          push_lim = 25;
          add_lim  = 55;
        end
        default: begin
          push_lim = 40;
          add_lim  = 65;
        end
      endcase
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < push_lim) add_cmd(OP_PUSH, rand_word(), rand_word());
        else if (r < add_lim) add_cmd(OP_ADD, rand_word(), rand_word());
        else if (r < 97) add_cmd(OP_OUT, rand_word(), rand_word());
        else add_cmd(OP_BAD, rand_word(), rand_word());
      end
    end
  endtask

  task automatic stack_predict(input logic [1:0] func, input logic [31:0] x,
                               input logic [31:0] y);
    vsc_result_t res;
    res = '0;
    res.status = ST_OK;
    case (func)
      FUNC_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_x[stack_fill] = x;
          stack_y[stack_fill] = y;
          stack_fill++;
        end
      end
      FUNC_ADD: begin
        if (stack_fill < 2) begin
          res.status = ST_UNDER;
        end else begin
          stack_x[stack_fill-2] = stack_x[stack_fill-1] + stack_x[stack_fill-2];
          stack_y[stack_fill-2] = stack_y[stack_fill-1] + stack_y[stack_fill-2];
          stack_fill--;
        end
      end
      FUNC_OUT: begin
        if (stack_fill == 0) begin
          res.status = ST_UNDER;
        end else begin
          stack_fill--;
          res.has_value = 1'b1;
          res.x = stack_x[stack_fill];
          res.y = stack_y[stack_fill];
        end
      end
      default: begin
        res.status = ST_BADCMD;
      end
    endcase
    results_due.push_back(res);
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_beat();
    vsc_result_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with none expected, actual status %0d value %0d x %h y %h",
               $time, out_status, out_has_value, out_x_out, out_y_out);
    end else begin
      want = results_due.pop_front();
      report_field("status", 32'(want.status), 32'(out_status));
      report_field("has_value", 32'(want.has_value), 32'(out_has_value));
      report_field("x_out", want.x, out_x_out);
      report_field("y_out", want.y, out_y_out);
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        stack_predict(in_func, in_x_in, in_y_in);
        n_accepted++;
      end
      if (!(in_push && in_full)) begin
        if (push_gap > 0) begin
          in_push <= 1'b0;
          push_gap--;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          in_func  <= next_cmd.op;
          in_x_in  <= next_cmd.x;
          in_y_in  <= next_cmd.y;
          in_push  <= 1'b1;
          push_gap = pick_gap(push_quiet);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_beat();
      if (pop_stall > 0) begin
        out_pop <= 1'b0;
        pop_stall--;
      end else begin
        out_pop <= 1'b1;
        pop_stall = pick_gap(pop_quiet);
      end
    end
  end

  initial begin
    build_stimulus();
    wait (n_accepted == n_total);
    wait (results_due.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: vector_stack_calculator.f
src/vsc_pkg.sv
src/vsc_front.sv
src/vsc_back.sv
src/vector_stack_calculator.sv
src/vsc_checker.sv
verif/testbench.sv
